// File: rtl/core/spq_pkg.sv
// Shared types and codes for the sorted priority queue with aging.
package spq_pkg;

  // Function codes on the func input
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_POP    = 2'd1;
  localparam logic [1:0] FUNC_AGE    = 2'd2;

  // Defaults of the top-level parameters
  localparam int DEF_CAPACITY = 16;
  localparam int DEF_KEY_BITS = 16;
  localparam int DEF_TAG_BITS = 8;

  // Depth of the command and result queues
  localparam int QUEUE_DEPTH = 2;

  // Operation after classification by the front end
  typedef enum logic [1:0] {
    OP_NOP,
    OP_INSERT,
    OP_POP,
    OP_AGE
  } op_t;

  // Control part of one command passed from front end to back end
  typedef struct packed {
    op_t  op;
    logic to_front;
  } spq_ctrl_t;

  // Status part of one result passed from back end to the output queue
  typedef struct packed {
    logic out_valid;
    logic is_empty;
    logic dropped;
  } spq_status_t;

endpackage

// File: rtl/core/spq_fifo.sv
// Small first-in first-out queue with full/empty handshake on both sides.
module spq_fifo
  import spq_pkg::*;
#(
  parameter int WIDTH = 1,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/spq_front.sv
// Front end: accept transactions, classify them into commands and queue them.
module spq_front
  import spq_pkg::*;
#(
  parameter int KEY_BITS = DEF_KEY_BITS,
  parameter int TAG_BITS = DEF_TAG_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          func,
  input  logic [KEY_BITS-1:0] new_key,
  input  logic [TAG_BITS-1:0] new_tag,
  input  logic                to_front,
  input  logic [KEY_BITS-1:0] now_time,
  output logic                cmd_valid,
  input  logic                cmd_take,
  output spq_ctrl_t           cmd_ctrl,
  output logic [KEY_BITS-1:0] cmd_key,
  output logic [TAG_BITS-1:0] cmd_tag
);

  localparam int CMD_BITS = $bits(spq_ctrl_t) + KEY_BITS + TAG_BITS;

  spq_ctrl_t           dec_ctrl;
  logic [KEY_BITS-1:0] dec_key;
  logic                cmd_empty;
  logic [CMD_BITS-1:0] cmd_rdata;

  // Age carries the current time in the key slot of the command
  always_comb begin
    dec_ctrl.op       = OP_NOP;
    dec_ctrl.to_front = 1'b0;
    dec_key           = new_key;
    unique case (func)
      FUNC_INSERT: begin
        dec_ctrl.op       = OP_INSERT;
        dec_ctrl.to_front = to_front;
      end
      FUNC_POP: begin
        dec_ctrl.op = OP_POP;
      end
      FUNC_AGE: begin
        dec_ctrl.op = OP_AGE;
        dec_key     = now_time;
      end
      default: begin
        dec_ctrl.op = OP_NOP;
      end
    endcase
  end

  spq_fifo #(
    .WIDTH (CMD_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({dec_ctrl, dec_key, new_tag}),
    .full  (full),
    .pop   (cmd_take),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  assign cmd_valid = !cmd_empty;
  assign {cmd_ctrl, cmd_key, cmd_tag} = cmd_rdata;

endmodule

// File: rtl/core/spq_back.sv
// Back end: sorted shift-register cell array and result queue.
module spq_back
  import spq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int KEY_BITS = DEF_KEY_BITS,
  parameter int TAG_BITS = DEF_TAG_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_take,
  input  spq_ctrl_t           cmd_ctrl,
  input  logic [KEY_BITS-1:0] cmd_key,
  input  logic [TAG_BITS-1:0] cmd_tag,
  output logic                empty,
  input  logic                pop,
  output logic                out_valid,
  output logic [TAG_BITS-1:0] out_tag,
  output logic [KEY_BITS-1:0] out_key,
  output logic                is_empty,
  output logic                dropped
);

  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int RES_BITS = $bits(spq_status_t) + TAG_BITS + KEY_BITS;

  logic [KEY_BITS-1:0] keys      [CAPACITY];
  logic [TAG_BITS-1:0] tags      [CAPACITY];
  logic [KEY_BITS-1:0] keys_next [CAPACITY];
  logic [TAG_BITS-1:0] tags_next [CAPACITY];
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;

  logic [CAPACITY-1:0] at_pos;   // cell lies at or after the insert point
  logic [CAPACITY-1:0] age_inc;  // cell lies in the aged run from the head

  spq_status_t         res_status;
  logic [TAG_BITS-1:0] res_tag;
  logic [KEY_BITS-1:0] res_key;
  logic                res_full;
  logic                res_push;
  logic [RES_BITS-1:0] res_rdata;
  spq_status_t         out_status;

  assign cmd_take = cmd_valid && !res_full;
  assign res_push = cmd_take;

  // Parallel compares, then prefix chains over the cells
  always_comb begin
    logic ins_acc;
    logic age_run;
    logic vld;
    ins_acc = cmd_ctrl.to_front;
    age_run = 1'b1;
    for (int i = 0; i < CAPACITY; i++) begin
      vld        = (CW'(i) < count);
      ins_acc    = ins_acc || !vld || (keys[i] > cmd_key);
      at_pos[i]  = ins_acc;
      age_run    = age_run && vld && (keys[i] < cmd_key);
      age_inc[i] = age_run;
    end
  end

  always_comb begin
    keys_next  = keys;
    tags_next  = tags;
    count_next = count;
    res_status = '0;
    res_tag    = '0;
    res_key    = '0;
    if (cmd_take) begin
      unique case (cmd_ctrl.op)
        OP_INSERT: begin
          if (count == CW'(CAPACITY)) begin
            res_status.dropped = 1'b1;
          end else begin
            if (at_pos[0]) begin
              keys_next[0] = cmd_key;
              tags_next[0] = cmd_tag;
            end
            for (int i = 1; i < CAPACITY; i++) begin
              if (at_pos[i]) begin
                keys_next[i] = at_pos[i-1] ? keys[i-1] : cmd_key;
                tags_next[i] = at_pos[i-1] ? tags[i-1] : cmd_tag;
              end
            end
            count_next = count + 1'b1;
          end
        end
        OP_POP: begin
          if (count != '0) begin
            res_status.out_valid = 1'b1;
            res_tag              = tags[0];
            res_key              = keys[0];
            for (int i = 0; i < CAPACITY - 1; i++) begin
              keys_next[i] = keys[i+1];
              tags_next[i] = tags[i+1];
            end
            count_next = count - 1'b1;
          end
        end
        OP_AGE: begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (age_inc[i] && (keys[i] != '1)) begin
              keys_next[i] = keys[i] + 1'b1;
            end
          end
        end
        OP_NOP: begin
        end
      endcase
    end
    res_status.is_empty = (count_next == '0);
  end

  always_ff @(posedge clk) begin
    keys <= keys_next;
    tags <= tags_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  spq_fifo #(
    .WIDTH (RES_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata ({res_status, res_tag, res_key}),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign {out_status, out_tag, out_key} = res_rdata;
  assign out_valid = out_status.out_valid;
  assign is_empty  = out_status.is_empty;
  assign dropped   = out_status.dropped;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd_take && (cmd_ctrl.op == OP_INSERT) && (count != CW'(CAPACITY))
    |=> count == $past(count) + 1'b1)
    else $error("accepted insert did not add an entry");

  a_drop_holds: assert property (@(posedge clk) disable iff (rst)
    res_push && res_status.dropped |=> count == CW'(CAPACITY))
    else $error("dropped insert changed the entry count");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    res_push && res_status.out_valid |=> count == $past(count) - 1'b1)
    else $error("returned entry did not leave the queue");

endmodule

// File: rtl/core/sorted_priority_queue_with_aging.sv
// Top level of the sorted priority queue with aging.
//
// Input channel: a transaction is taken at a rising edge with push high and
// full low. func selects insert (new_key, new_tag, to_front), pop of the
// head entry, or age (now_time); the unused code only reports is_empty.
// Result channel: one result per input transaction, in order. The oldest
// result sits on out_valid/out_tag/out_key/is_empty/dropped while empty is
// low and leaves at a rising edge with pop high.
// The command waits in the command queue until the back end takes it; the
// cell array updates and queues the result at the same edge that takes the
// command, and the result is visible after that edge.
// Throughput: one transaction per cycle while the result side keeps up; the
// cell array compares all entries in parallel, so insert, pop and age each finish in a single update.
// When the result side stalls, the two-entry result queue fills, the cell
// array holds, then the two-entry command queue fills and full rises.
// Reset clears the entry count and both queues; entry contents are not
// cleared and are never read before written. No clearing pass is needed.
// Inserting into a full queue drops the entry and flags dropped.
module sorted_priority_queue_with_aging
  import spq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int KEY_BITS = DEF_KEY_BITS,
  parameter int TAG_BITS = DEF_TAG_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          func,
  input  logic [KEY_BITS-1:0] new_key,
  input  logic [TAG_BITS-1:0] new_tag,
  input  logic                to_front,
  input  logic [KEY_BITS-1:0] now_time,
  output logic                empty,
  input  logic                pop,
  output logic                out_valid,
  output logic [TAG_BITS-1:0] out_tag,
  output logic [KEY_BITS-1:0] out_key,
  output logic                is_empty,
  output logic                dropped
);

  // Command handoff between front end and back end
  logic                cmd_valid;
  logic                cmd_take;
  spq_ctrl_t           cmd_ctrl;
  logic [KEY_BITS-1:0] cmd_key;
  logic [TAG_BITS-1:0] cmd_tag;

  // Front end: decode func and park the command in a short queue
  spq_front #(
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .func      (func),
    .new_key   (new_key),
    .new_tag   (new_tag),
    .to_front  (to_front),
    .now_time  (now_time),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd_ctrl  (cmd_ctrl),
    .cmd_key   (cmd_key),
    .cmd_tag   (cmd_tag)
  );

  // Back end: execute one command per cycle while the result queue has room
  spq_back #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd_ctrl  (cmd_ctrl),
    .cmd_key   (cmd_key),
    .cmd_tag   (cmd_tag),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_tag   (out_tag),
    .out_key   (out_key),
    .is_empty  (is_empty),
    .dropped   (dropped)
  );

endmodule

// File: dv/tb_sorted_priority_queue_with_aging.sv
// Testbench for the sorted priority queue with aging.
`timescale 1ns / 100ps

module tb_sorted_priority_queue_with_aging;
  import spq_pkg::*;

  localparam int CAPACITY = DEF_CAPACITY;
  localparam int KEY_BITS = DEF_KEY_BITS;
  localparam int TAG_BITS = DEF_TAG_BITS;

  // The package names only the three live codes; the fourth is a no-op.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Give up long after the slowest legal run.
  localparam int RUN_LIMIT_NS = 2_000_000;

  // One result transaction, in port order.
  typedef struct packed {
    logic                out_valid;
    logic [TAG_BITS-1:0] out_tag;
    logic [KEY_BITS-1:0] out_key;
    logic                is_empty;
    logic                dropped;
  } queue_result_t;

  // Drive every input to a known value from time zero.
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic [1:0]          func = FUNC_UNUSED;
  logic [KEY_BITS-1:0] new_key = '0;
  logic [TAG_BITS-1:0] new_tag = '0;
  logic                to_front = 1'b0;
  logic [KEY_BITS-1:0] now_time = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic                out_valid;
  logic [TAG_BITS-1:0] out_tag;
  logic [KEY_BITS-1:0] out_key;
  logic                is_empty;
  logic                dropped;

  sorted_priority_queue_with_aging DUT (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .func     (func),
    .new_key  (new_key),
    .new_tag  (new_tag),
    .to_front (to_front),
    .now_time (now_time),
    .empty    (empty),
    .pop      (pop),
    .out_valid(out_valid),
    .out_tag  (out_tag),
    .out_key  (out_key),
    .is_empty (is_empty),
    .dropped  (dropped)
  );

  // 4 ns period: 2 ns high, 2 ns low.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the ordered store, kept in step with accepted transactions.
  logic [KEY_BITS-1:0] shadow_keys [CAPACITY];
  logic [TAG_BITS-1:0] shadow_tags [CAPACITY];
  int                  shadow_count = 0;

  // Results predicted but not yet seen on the result side, oldest first.
  queue_result_t pending_results [$];

  // Percent chance of an idle cycle on each side.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  int mismatches = 0;
  int results_seen = 0;

  // Tally of what the accepted stimulus exercised, for the summary.
  int n_inserted = 0;
  int n_front = 0;
  int n_dropped = 0;
  int n_popped = 0;
  int n_empty_pops = 0;
  int n_aged = 0;
  int n_unused = 0;
  int n_sent = 0;

  // Apply one transaction to the shadow store and return the result it causes.
  function automatic queue_result_t queue_step(input logic [1:0] f,
                                               input logic [KEY_BITS-1:0] key,
                                               input logic [TAG_BITS-1:0] tag,
                                               input logic front,
                                               input logic [KEY_BITS-1:0] now_val);
    queue_result_t res;
    int            pos;
    logic          found;
    logic          bumped;
    res = '0;
    found = 1'b0;
    bumped = 1'b0;
    case (f)
      FUNC_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          res.dropped = 1'b1;
          n_dropped++;
        end else begin
          // Land after every key that is less than or equal to the new one.
          pos = front ? 0 : shadow_count;
          for (int i = 0; i < shadow_count && !front && !found; i++) begin
            if (shadow_keys[i] > key) begin
              pos = i;
              found = 1'b1;
            end
          end
          for (int i = shadow_count; i > pos; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_tags[i] = shadow_tags[i-1];
          end
          shadow_keys[pos] = key;
          shadow_tags[pos] = tag;
          shadow_count++;
          n_inserted++;
          if (front) n_front++;
        end
      end
      FUNC_POP: begin
        if (shadow_count > 0) begin
          res.out_valid = 1'b1;
          res.out_tag = shadow_tags[0];
          res.out_key = shadow_keys[0];
          shadow_count--;
          for (int i = 0; i < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
            shadow_tags[i] = shadow_tags[i+1];
          end
          n_popped++;
        end else begin
          n_empty_pops++;
        end
      end
      FUNC_AGE: begin
        // Bump keys from the head while they are older than now; stop at the first
        // that is not. Saturate at all ones.
        for (int i = 0; i < shadow_count && !found; i++) begin
          if (shadow_keys[i] < now_val) begin
            if (shadow_keys[i] != '1) shadow_keys[i] = shadow_keys[i] + 1'b1;
            bumped = 1'b1;
          end else begin
            found = 1'b1;
          end
        end
        if (bumped) n_aged++;
      end
      default: n_unused++;
    endcase
    res.is_empty = (shadow_count == 0);
    return res;
  endfunction

  // Send one transaction: idle at random, hold push until full drops, then
  // predict at the accepting edge. Leave push high so back-to-back transactions
  // never lower and raise it in the same step.
  task automatic send_op(input logic [1:0] f, input logic [KEY_BITS-1:0] key,
                         input logic [TAG_BITS-1:0] tag, input logic front,
                         input logic [KEY_BITS-1:0] now_val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    func <= f;
    new_key <= key;
    new_tag <= tag;
    to_front <= front;
    now_time <= now_val;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_results.push_back(queue_step(f, key, tag, front, now_val));
    n_sent++;
  endtask

  // Fill fields that the operation ignores with random values.
  task automatic insert_entry(input logic [KEY_BITS-1:0] key,
                              input logic [TAG_BITS-1:0] tag, input logic front);
    send_op(FUNC_INSERT, key, tag, front, KEY_BITS'($urandom));
  endtask

  task automatic pop_head();
    send_op(FUNC_POP, KEY_BITS'($urandom), TAG_BITS'($urandom), 1'($urandom),
            KEY_BITS'($urandom));
  endtask

  task automatic age_entries(input logic [KEY_BITS-1:0] now_val);
    send_op(FUNC_AGE, KEY_BITS'($urandom), TAG_BITS'($urandom), 1'($urandom), now_val);
  endtask

  task automatic send_unused();
    send_op(FUNC_UNUSED, KEY_BITS'($urandom), TAG_BITS'($urandom), 1'($urandom),
            KEY_BITS'($urandom));
  endtask

  // Pop, age and no-op on an empty queue: nothing to return, nothing to age.
  task automatic test_empty_queue_ops();
    pop_head();
    age_entries('1);
    send_unused();
  endtask

  // Key extremes, equal keys kept in arrival order, head insert ignoring key.
  task automatic test_ordering();
    insert_entry('1, '1, 1'b0);
    insert_entry('0, '0, 1'b0);
    insert_entry(16'h8000, 8'hAA, 1'b0);
    insert_entry(16'h8000, 8'h55, 1'b0);
    insert_entry('1, 8'h11, 1'b1);
    pop_head();
  endtask

  // Queue now holds 0, 8000, 8000, FFFF. Age up to the top key, then with a
  // time below the head, then where the walk stops on the second entry.
  task automatic test_aging();
    age_entries('1);
    age_entries('0);
    age_entries(16'h8001);
    send_unused();
  endtask

  // Fill to capacity, then try a head insert into the full queue.
  task automatic test_overflow();
    while (shadow_count < CAPACITY) begin
      insert_entry(KEY_BITS'($urandom), TAG_BITS'($urandom), 1'($urandom_range(0, 3) == 0));
    end
    insert_entry('0, '1, 1'b1);
  endtask

  // Mixed traffic around a drifting time base, switching between fill-heavy and
  // drain-heavy stretches so both the full and the empty corners keep coming up.
  task automatic test_random_mix(input int n_items);
    logic [KEY_BITS-1:0] time_base;
    logic                filling;
    int                  stretch;
    int                  r;
    int                  ins_cut;
    logic [KEY_BITS-1:0] key;
    logic [KEY_BITS-1:0] now_val;
    time_base = KEY_BITS'($urandom);
    filling = 1'b1;
    stretch = $urandom_range(30, 120);
    for (int n = 0; n < n_items; n++) begin
      if (stretch == 0) begin
        filling = !filling;
        stretch = $urandom_range(30, 120);
      end
      stretch--;
      // Mostly keys near the time base so ages hit; now and then anything.
      key = ($urandom_range(0, 9) == 0) ? KEY_BITS'($urandom)
                                        : time_base + KEY_BITS'($urandom_range(0, 40));
      now_val = ($urandom_range(0, 9) == 0) ? KEY_BITS'($urandom)
                                            : time_base + KEY_BITS'($urandom_range(0, 60));
      time_base = time_base + KEY_BITS'($urandom_range(0, 3));
      ins_cut = filling ? 68 : 42;
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_unused();
      end else if (r < 18) begin
        age_entries(now_val);
      end else if (r < ins_cut) begin
        insert_entry(key, TAG_BITS'($urandom), 1'($urandom_range(0, 9) == 0));
      end else begin
        pop_head();
      end
    end
  endtask

  // Result side: pop at random, check each accepted result against the oldest
  // prediction. Sample at the edge, so values are those the DUT saw.
  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    if (!rst) begin
      if (pop && !empty) begin
        got = '{out_valid, out_tag, out_key, is_empty, dropped};
        results_seen++;
        if (pending_results.size() == 0) begin
          if (mismatches < 10) begin
            $display("[%0t] unexpected result: valid=%0b tag=%02h key=%04h empty=%0b drop=%0b",
                     $realtime, got.out_valid, got.out_tag, got.out_key, got.is_empty,
                     got.dropped);
          end
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("[%0t] result %0d mismatch", $realtime, results_seen);
              $display("  expected valid=%0b tag=%02h key=%04h empty=%0b drop=%0b",
                       want.out_valid, want.out_tag, want.out_key, want.is_empty,
                       want.dropped);
              $display("  actual   valid=%0b tag=%02h key=%04h empty=%0b drop=%0b",
                       got.out_valid, got.out_tag, got.out_key, got.is_empty,
                       got.dropped);
            end
            mismatches++;
          end
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    // Hold reset once, at the start.
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Slow receiver first: the result and command queues back up and full rises.
    send_idle_pct = 18;
    recv_idle_pct = 87;
    test_empty_queue_ops();
    test_ordering();
    test_aging();
    test_overflow();
    test_random_mix(600);

    // Then a slow sender and a mostly ready receiver.
    send_idle_pct = 87;
    recv_idle_pct = 18;
    test_random_mix(600);

    // Then full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(600);
    push <= 1'b0;

    // Drain, then linger to catch any stray result.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d transactions, checked %0d results: %0d inserts (%0d at head),",
             n_sent, results_seen, n_inserted, n_front);
    $display("  %0d drops on full, %0d pops, %0d pops on empty, %0d aging walks, %0d no-ops",
             n_dropped, n_popped, n_empty_pops, n_aged, n_unused);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
